[hdl/dhoa_pkg.sv]
// ============================================================================
// Double-hash table package
// Shared types, sizes and codes of the double-hashing key/value table.
// ============================================================================
`timescale 1ns / 1ps

package dhoa_pkg;

  localparam int TABLE_SLOTS = 127;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int LEN_W   = 4;
  localparam int KEY_W   = 64;
  localparam int MULT_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Width of the value fed to the modular reducer: a product of two residues
  // plus a character, or a raw multiplier register.
  localparam int RED_W   = ((2 * IDX_W) > MULT_W ? (2 * IDX_W) : MULT_W) + 1;
  localparam int RCP_W   = RED_W + 1;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'((64'(1) << RED_W) / 64'(TABLE_SLOTS));

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MULT_A = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_B = 1'd1;

  localparam int SLOT_W = KEY_W + LEN_W + VALUE_BITS;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value_out;
    logic [6:0]  live_entries;
  } out_item_t;

  // Classified item handed from the hashing front to the probe engine.
  typedef struct packed {
    logic [1:0]            opcode;
    logic [KEY_W-1:0]      key;
    logic [LEN_W-1:0]      len;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      home;
    logic [IDX_W-1:0]      step;
  } job_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [LEN_W-1:0]      len;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/dhoa_ram.sv]
// ============================================================================
// Generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module dhoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/dhoa_front.sv]
// ============================================================================
// Hash front
// Accepts items, normalizes the key and computes both polynomial hashes
// with a three-step multiply and reciprocal reduction per character.
// ============================================================================
`timescale 1ns / 1ps

module dhoa_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dhoa_pkg::in_item_t             in_data,
  input  logic [dhoa_pkg::MULT_W-1:0]    mult_a,
  input  logic [dhoa_pkg::MULT_W-1:0]    mult_b,
  input  dhoa_pkg::q_stat_t              q_stat,
  output logic                           push,
  output dhoa_pkg::job_t                 push_job
);
  import dhoa_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_QUO  = 5'b00100,
    F_REM  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [KEY_W-1:0]      key_r;
  logic [LEN_W-1:0]      len_r;
  logic [1:0]            op_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  mred_r;
  logic [LEN_W-1:0]      pos_r;
  logic [IDX_W-1:0]      ma_r, mb_r, ha_r, hb_r;
  logic [RED_W-1:0]      pa_r, pb_r, qa_r, qb_r;

  logic [LEN_W-1:0]      len_c;
  logic [KEY_W-1:0]      key_c;
  logic [7:0]            chr;
  logic [IDX_W:0]        ra, rb, ra_fix, rb_fix;
  logic [IDX_W:0]        step_sum;

  always_comb begin
    len_c = (in_data.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                     : in_data.key_length;
    key_c = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LEN_W'(i) < len_c) begin
        key_c[8*i +: 8] = in_data.key_bytes[8*i +: 8];
      end
    end
  end

  assign chr = key_r[8*pos_r[2:0] +: 8];

  // Quotient estimate is low by at most one, so one subtract finishes.
  assign ra     = (IDX_W+1)'(pa_r - RED_W'(qa_r * TABLE_SLOTS));
  assign rb     = (IDX_W+1)'(pb_r - RED_W'(qb_r * TABLE_SLOTS));
  assign ra_fix = (ra >= (IDX_W+1)'(TABLE_SLOTS)) ? ra - (IDX_W+1)'(TABLE_SLOTS) : ra;
  assign rb_fix = (rb >= (IDX_W+1)'(TABLE_SLOTS)) ? rb - (IDX_W+1)'(TABLE_SLOTS) : rb;

  assign step_sum = {1'b0, hb_r} + (IDX_W+1)'(1);

  assign in_ready = (state_r == F_IDLE);
  assign push     = (state_r == F_PUSH) && !q_stat.full;

  always_comb begin
    push_job.opcode = op_r;
    push_job.key    = key_r;
    push_job.len    = len_r;
    push_job.value  = val_r;
    push_job.home   = ha_r;
    push_job.step   = (step_sum == (IDX_W+1)'(TABLE_SLOTS)) ? '0 : IDX_W'(step_sum);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL:  state_nxt = F_QUO;
      F_QUO:  state_nxt = F_REM;
      F_REM: begin
        if ((mred_r ? pos_r : pos_r + LEN_W'(1)) == len_r) begin
          state_nxt = F_PUSH;
        end else begin
          state_nxt = F_MUL;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          key_r  <= key_c;
          len_r  <= len_c;
          op_r   <= in_data.opcode;
          val_r  <= VALUE_BITS'(in_data.value_in);
          mred_r <= 1'b1;
          pos_r  <= '0;
          ha_r   <= '0;
          hb_r   <= '0;
        end
      end
      F_MUL: begin
        if (mred_r) begin
          pa_r <= RED_W'(mult_a);
          pb_r <= RED_W'(mult_b);
        end else begin
          pa_r <= RED_W'(ha_r) * RED_W'(ma_r) + RED_W'(chr);
          pb_r <= RED_W'(hb_r) * RED_W'(mb_r) + RED_W'(chr);
        end
      end
      F_QUO: begin
        qa_r <= RED_W'(({{RCP_W{1'b0}}, pa_r} * RECIP) >> RED_W);
        qb_r <= RED_W'(({{RCP_W{1'b0}}, pb_r} * RECIP) >> RED_W);
      end
      F_REM: begin
        if (mred_r) begin
          ma_r   <= IDX_W'(ra_fix);
          mb_r   <= IDX_W'(rb_fix);
          mred_r <= 1'b0;
        end else begin
          ha_r  <= IDX_W'(ra_fix);
          hb_r  <= IDX_W'(rb_fix);
          pos_r <= pos_r + LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/dhoa_queue.sv]
// ============================================================================
// Job queue
// Short first-in first-out buffer between the hash front and probe engine.
// ============================================================================
`timescale 1ns / 1ps

module dhoa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dhoa_pkg::job_t    push_job,
  input  logic              pop,
  output dhoa_pkg::job_t    pop_job,
  output dhoa_pkg::q_stat_t q_stat
);
  import dhoa_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_job      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

[hdl/dhoa_back.sv]
// ============================================================================
// Probe engine
// Walks the probe sequence of one job over the slot memory and the slot
// marks, updates the table and registers the result.
// ============================================================================
`timescale 1ns / 1ps

module dhoa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dhoa_pkg::job_t     pop_job,
  input  dhoa_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output dhoa_pkg::out_item_t out_data
);
  import dhoa_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_EVAL = 4'b0100,
    B_RESP = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  job_t                  job_r;
  logic [IDX_W-1:0]      idx_r;
  logic [CNT_W-1:0]      probes_r;
  logic [CNT_W-1:0]      live_cnt_r;
  logic [TABLE_SLOTS-1:0] live_r, tomb_r;
  logic                  found_r;
  logic [1:0]            status_r;
  logic [VALUE_BITS-1:0] vout_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  ram_we;
  slot_t                 ram_wdata, ram_rdata;
  logic                  is_live, is_tomb, key_eq, last_probe;
  logic [IDX_W:0]        idx_sum;
  logic [IDX_W-1:0]      idx_next;

  dhoa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign is_live    = live_r[idx_r];
  assign is_tomb    = tomb_r[idx_r];
  assign key_eq     = (ram_rdata.len == job_r.len) && (ram_rdata.key == job_r.key);
  assign last_probe = (probes_r == CNT_W'(TABLE_SLOTS - 1));
  assign idx_sum    = {1'b0, idx_r} + {1'b0, job_r.step};
  assign idx_next   = (idx_sum >= (IDX_W+1)'(TABLE_SLOTS))
                      ? IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SLOTS)) : IDX_W'(idx_sum);

  assign ram_wdata.key   = job_r.key;
  assign ram_wdata.len   = job_r.len;
  assign ram_wdata.value = job_r.value;
  assign ram_we = (state_r == B_EVAL) && (job_r.opcode == OP_INSERT)
                  && (!is_live || key_eq);

  assign pop       = (state_r == B_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (pop_job.opcode == OP_NOP) ? B_RESP : B_READ;
        end
      end
      B_READ: state_nxt = B_EVAL;
      B_EVAL: begin
        case (job_r.opcode)
          OP_INSERT: state_nxt = (!is_live || key_eq || last_probe) ? B_RESP : B_READ;
          OP_SEARCH: state_nxt = ((!is_live && !is_tomb) || (is_live && key_eq)
                                  || last_probe) ? B_RESP : B_READ;
          default:   state_nxt = ((!is_live && !is_tomb) || last_probe) ? B_RESP : B_READ;
        endcase
      end
      B_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      live_r      <= '0;
      tomb_r      <= '0;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_EVAL) begin
        if (job_r.opcode == OP_INSERT) begin
          if (!is_live) begin
            live_r[idx_r] <= 1'b1;
            tomb_r[idx_r] <= 1'b0;
            live_cnt_r    <= live_cnt_r + CNT_W'(1);
          end
        end else if (job_r.opcode == OP_DELETE) begin
          if (is_live && key_eq) begin
            live_r[idx_r] <= 1'b0;
            tomb_r[idx_r] <= 1'b1;
            if (live_cnt_r != '0) begin
              live_cnt_r <= live_cnt_r - CNT_W'(1);
            end
          end
        end
      end
      if (state_r == B_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r    <= pop_job;
        idx_r    <= pop_job.home;
        probes_r <= '0;
        found_r  <= 1'b0;
        vout_r   <= '0;
        status_r <= ST_DONE;
      end
      B_EVAL: begin
        probes_r <= probes_r + CNT_W'(1);
        case (job_r.opcode)
          OP_INSERT: begin
            if (is_live && key_eq) begin
              found_r <= 1'b1;
            end else if (is_live) begin
              idx_r <= idx_next;
              if (last_probe) begin
                status_r <= ST_FULL;
              end
            end
          end
          OP_SEARCH: begin
            if (is_live && key_eq) begin
              found_r <= 1'b1;
              vout_r  <= ram_rdata.value;
            end else begin
              idx_r <= idx_next;
              if (!(is_live || is_tomb) || last_probe) begin
                status_r <= ST_MISS;
              end
            end
          end
          default: begin
            idx_r <= idx_next;
            if (is_live && key_eq) begin
              found_r <= 1'b1;
            end else if ((!(is_live || is_tomb) || last_probe) && !found_r) begin
              status_r <= ST_MISS;
            end
          end
        endcase
      end
      B_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_r.status       <= status_r;
          out_r.found        <= found_r;
          out_r.value_out    <= 32'(vout_r);
          out_r.live_entries <= 7'(live_cnt_r);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/double_hash_open_address_table_core.sv]
// ============================================================================
// Double-hash open-address table core
// Key/value table with open addressing, double hashing and tombstones.
// ============================================================================
// Each transfer on the input channel is an insert, search, delete or no-op
// on a table of TABLE_SLOTS slots, and it yields exactly one result transfer.
// An item first passes a hash front that reduces both multiplier registers
// modulo the slot count and then folds in one key character at a time by a
// multiply, a reciprocal quotient and a remainder step before it hands the
// job on. A two-entry queue then feeds the probe engine, which uses the
// single read port of the slot memory in a read step and an evaluate step
// per probe, after a dispatch step and before a result step. The front
// hashes the next item while the engine is still probing, and a finished
// result waits in the output register while the engine takes the next job,
// which stalls in its result step until the waiting result is taken.
// Slot marks live in flip-flops and are cleared by reset, so the table is
// usable in the cycle after reset is released. The multiplier registers are
// written through the cfg_ port; the user must write them only while no
// operation is in flight, which the block itself does not enforce.
// ============================================================================
`timescale 1ns / 1ps

module double_hash_open_address_table_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dhoa_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dhoa_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [dhoa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dhoa_pkg::MULT_W-1:0]      cfg_wdata
);
  import dhoa_pkg::*;

  logic [MULT_W-1:0] mult_a_r, mult_b_r;
  logic              push, pop;
  job_t              push_job, pop_job;
  q_stat_t           q_stat;

  // Hash multipliers; values of 0 or 1 are used exactly as written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_a_r <= MULT_W'(151);
      mult_b_r <= MULT_W'(163);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MULT_A: mult_a_r <= cfg_wdata;
        CFG_MULT_B: mult_b_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dhoa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .mult_a   (mult_a_r),
    .mult_b   (mult_b_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  dhoa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  dhoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/dhoa_checker.sv]
// ============================================================================
// Table port checker
// Assertions on the result channel of the table core, bound to the top.
// ============================================================================
`timescale 1ns / 1ps

module dhoa_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dhoa_pkg::out_item_t out_data
);
  import dhoa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_DONE || out_data.status == ST_MISS
                  || out_data.status == ST_FULL)
    else $error("reserved status code");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> !out_data.found)
    else $error("full table reported a match");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.value_out == '0)
    else $error("value returned without a match");

endmodule

bind double_hash_open_address_table_core dhoa_port_checker u_dhoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
